/* rtl/core/apcm_pkg.sv */
// Package for the box pair contact manifold: widths, coordinate types, the axis code,
// the manifold record and the helpers that widen, narrow and clamp values.
// No dependencies.
package apcm_pkg;

   localparam int unsigned CoordWidth  = 32;   // internal min/max width, wraps
   localparam int unsigned CenterWidth = 31;
   localparam int unsigned ExtentWidth = 30;
   localparam int unsigned PenWidth    = 31;
   localparam int unsigned OutWidth    = 32;
   localparam int unsigned NumAxes     = 3;
   localparam int unsigned NumContacts = 4;
   localparam int unsigned CountWidth  = $clog2(NumContacts);

   typedef logic signed [CenterWidth-1:0]  center_type;
   typedef logic        [ExtentWidth-1:0]  extent_type;
   typedef logic        [PenWidth-1:0]     pen_type;
   typedef logic signed [OutWidth-1:0]     out_coord_type;
   typedef logic signed [CoordWidth-1:0]   coord_type;
   typedef logic signed [CoordWidth:0]     span_type;   // overlap, or sum of two coords
   typedef logic signed [CoordWidth+1:0]   diff_type;   // difference of two sums
   typedef logic        [CountWidth-1:0]   count_type;

   typedef enum logic [1:0] {
      AxisX = 2'd0,
      AxisY = 2'd1,
      AxisZ = 2'd2
   } axis_type;

   // One box pair after axis selection, waiting to be sent as items.
   typedef struct packed {
      logic                         hit;
      pen_type                      penetration;
      axis_type                     axis;
      logic                         negative;
      coord_type                    plane;
      logic [NumAxes-1:0][CoordWidth-1:0] hi;
      logic [NumAxes-1:0][CoordWidth-1:0] lo;
   } manifold_type;

   function automatic coord_type center_to_coord(center_type v);
      logic signed [63:0] w;
      w = 64'(v);
      return coord_type'(w[CoordWidth-1:0]);
   endfunction

   function automatic coord_type extent_to_coord(extent_type v);
      logic [63:0] w;
      w = 64'(v);
      return coord_type'(w[CoordWidth-1:0]);
   endfunction

   function automatic out_coord_type coord_to_out(coord_type v);
      logic signed [63:0] w;
      w = 64'(v);
      return out_coord_type'(w[OutWidth-1:0]);
   endfunction

   function automatic span_type widen_span(coord_type v);
      return {v[CoordWidth-1], v};
   endfunction

   function automatic diff_type widen_diff(span_type v);
      return {v[CoordWidth], v};
   endfunction

   // Clamp an overlap depth to 0 .. 2^31-1.
   function automatic pen_type saturate_pen(span_type v);
      logic signed [64:0] w;
      w = 65'(v);
      if (w[64]) begin
         return '0;
      end else if (w[63:PenWidth] != '0) begin
         return '1;
      end else begin
         return w[PenWidth-1:0];
      end
   endfunction

endpackage

/* rtl/core/apcm_if.sv */
// Valid/ready channel interfaces for box pair items and contact result items.
// Depends on apcm_pkg.
interface apcm_req_if;
   logic                  valid;
   logic                  ready;
   apcm_pkg::center_type  src_center_x;
   apcm_pkg::center_type  src_center_y;
   apcm_pkg::center_type  src_center_z;
   apcm_pkg::extent_type  src_extent_x;
   apcm_pkg::extent_type  src_extent_y;
   apcm_pkg::extent_type  src_extent_z;
   apcm_pkg::center_type  tgt_center_x;
   apcm_pkg::center_type  tgt_center_y;
   apcm_pkg::center_type  tgt_center_z;
   apcm_pkg::extent_type  tgt_extent_x;
   apcm_pkg::extent_type  tgt_extent_y;
   apcm_pkg::extent_type  tgt_extent_z;

   modport source (
      output valid,
      input  ready,
      output src_center_x, src_center_y, src_center_z,
      output src_extent_x, src_extent_y, src_extent_z,
      output tgt_center_x, tgt_center_y, tgt_center_z,
      output tgt_extent_x, tgt_extent_y, tgt_extent_z
   );
   modport sink (
      input  valid,
      output ready,
      input  src_center_x, src_center_y, src_center_z,
      input  src_extent_x, src_extent_y, src_extent_z,
      input  tgt_center_x, tgt_center_y, tgt_center_z,
      input  tgt_extent_x, tgt_extent_y, tgt_extent_z
   );
endinterface

interface apcm_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     hit;
   apcm_pkg::pen_type        penetration;
   logic [1:0]               normal_axis;
   logic                     normal_negative;
   apcm_pkg::out_coord_type  contact_x;
   apcm_pkg::out_coord_type  contact_y;
   apcm_pkg::out_coord_type  contact_z;
   logic                     last_result;

   modport source (
      output valid,
      input  ready,
      output hit, penetration, normal_axis, normal_negative,
      output contact_x, contact_y, contact_z, last_result
   );
   modport sink (
      input  valid,
      output ready,
      input  hit, penetration, normal_axis, normal_negative,
      input  contact_x, contact_y, contact_z, last_result
   );
endinterface

/* rtl/core/apcm_emitter.sv */
// Result stage: holds one manifold and sends it as one miss item or four contact items.
// Depends on apcm_pkg and apcm_rsp_if.
module apcm_emitter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   input  apcm_pkg::manifold_type  load_data,
   output logic                    take,
   apcm_rsp_if.source              rsp
);

   logic                    valid_ff, valid_in;
   apcm_pkg::manifold_type  mf_ff, mf_in;
   apcm_pkg::count_type     count_ff, count_in;
   logic                    last;
   apcm_pkg::coord_type     pick0, pick1, cx, cy, cz;

   assign last = !mf_ff.hit || (count_ff == apcm_pkg::count_type'(apcm_pkg::NumContacts - 1));
   assign take = !valid_ff || (rsp.ready && last);

   always_comb begin
      valid_in = valid_ff;
      mf_in    = mf_ff;
      count_in = count_ff;
      if (take) begin
         valid_in = load_valid;
         mf_in    = load_data;
         count_in = '0;
      end else if (rsp.ready) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      mf_ff <= mf_in;
   end

   // First free axis follows count bit 0, second free axis count bit 1.
   always_comb begin
      pick0 = '0;
      pick1 = '0;
      cx    = '0;
      cy    = '0;
      cz    = '0;
      unique case (mf_ff.axis)
         apcm_pkg::AxisX: begin
            pick0 = count_ff[0] ? mf_ff.lo[1] : mf_ff.hi[1];
            pick1 = count_ff[1] ? mf_ff.lo[2] : mf_ff.hi[2];
            cx = mf_ff.plane;  cy = pick0;  cz = pick1;
         end
         apcm_pkg::AxisY: begin
            pick0 = count_ff[0] ? mf_ff.lo[0] : mf_ff.hi[0];
            pick1 = count_ff[1] ? mf_ff.lo[2] : mf_ff.hi[2];
            cx = pick0;  cy = mf_ff.plane;  cz = pick1;
         end
         apcm_pkg::AxisZ: begin
            pick0 = count_ff[0] ? mf_ff.lo[0] : mf_ff.hi[0];
            pick1 = count_ff[1] ? mf_ff.lo[1] : mf_ff.hi[1];
            cx = pick0;  cy = pick1;  cz = mf_ff.plane;
         end
         default: begin
            cx = '0;
         end
      endcase
      if (!mf_ff.hit) begin
         cx = '0;
         cy = '0;
         cz = '0;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.hit             = mf_ff.hit;
   assign rsp.penetration     = mf_ff.penetration;
   assign rsp.normal_axis     = mf_ff.axis;
   assign rsp.normal_negative = mf_ff.negative;
   assign rsp.contact_x       = apcm_pkg::coord_to_out(cx);
   assign rsp.contact_y       = apcm_pkg::coord_to_out(cy);
   assign rsp.contact_z       = apcm_pkg::coord_to_out(cz);
   assign rsp.last_result     = last;

`ifndef ASSERT_OFF
   a_miss_single: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> rsp.last_result && rsp.penetration == '0)
      else $error("miss item not final or has depth");
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last_result |=> rsp.valid && rsp.hit)
      else $error("contact burst cut short");
   a_burst_shared: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last_result |=>
         $stable(rsp.penetration) && $stable(rsp.normal_axis) && $stable(rsp.normal_negative))
      else $error("depth or normal changed within a burst");
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> take)
      else $error("empty result stage refused a manifold");
`endif

endmodule

/* rtl/core/aabb_pair_contact_manifold.sv */
// Box pair contact manifold, top level: min/max stage, overlap stage, axis pick
// into the result stage. Depends on apcm_pkg, apcm_if and apcm_emitter.
// A pair passes the min/max and overlap stage registers and then the result stage register.
// Throughput: a new pair every cycle into the pipe while the result stage takes pairs;
// the result stage sends one item a cycle while rsp.ready is high: four per hit, one per miss.
// Reset: synchronous, active high; clears all stage valids and the item counter.
module aabb_pair_contact_manifold (
   input  logic        clock,
   input  logic        reset,
   apcm_req_if.sink    req,
   apcm_rsp_if.source  rsp
);

   localparam int unsigned N = apcm_pkg::NumAxes;

   // ---------------------------------------------------------------
   // Pipe control: each stage moves when the one after it has room.
   // ---------------------------------------------------------------
   logic va_ff, va_in;     // min/max stage
   logic vb_ff, vb_in;     // overlap stage
   logic en_a, en_b, take;

   assign en_b      = !vb_ff || take;
   assign en_a      = !va_ff || en_b;
   assign req.ready = en_a;
   assign va_in     = en_a ? req.valid : va_ff;
   assign vb_in     = en_b ? va_ff : vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage A: box corners, min = c - e, max = c + e, wrapped to coord width.
   // ---------------------------------------------------------------
   apcm_pkg::coord_type sc [N];
   apcm_pkg::coord_type se [N];
   apcm_pkg::coord_type tc [N];
   apcm_pkg::coord_type te [N];
   apcm_pkg::coord_type smin_ff [N], smin_in [N];
   apcm_pkg::coord_type smax_ff [N], smax_in [N];
   apcm_pkg::coord_type tmin_ff [N], tmin_in [N];
   apcm_pkg::coord_type tmax_ff [N], tmax_in [N];

   always_comb begin
      sc[0] = apcm_pkg::center_to_coord(req.src_center_x);
      sc[1] = apcm_pkg::center_to_coord(req.src_center_y);
      sc[2] = apcm_pkg::center_to_coord(req.src_center_z);
      se[0] = apcm_pkg::extent_to_coord(req.src_extent_x);
      se[1] = apcm_pkg::extent_to_coord(req.src_extent_y);
      se[2] = apcm_pkg::extent_to_coord(req.src_extent_z);
      tc[0] = apcm_pkg::center_to_coord(req.tgt_center_x);
      tc[1] = apcm_pkg::center_to_coord(req.tgt_center_y);
      tc[2] = apcm_pkg::center_to_coord(req.tgt_center_z);
      te[0] = apcm_pkg::extent_to_coord(req.tgt_extent_x);
      te[1] = apcm_pkg::extent_to_coord(req.tgt_extent_y);
      te[2] = apcm_pkg::extent_to_coord(req.tgt_extent_z);
      for (int a = 0; a < N; a++) begin
         smin_in[a] = sc[a] - se[a];
         smax_in[a] = sc[a] + se[a];
         tmin_in[a] = tc[a] - te[a];
         tmax_in[a] = tc[a] + te[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         smin_ff <= smin_in;
         smax_ff <= smax_in;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: inclusive separation test, overlap interval, depth, and
   // the corner sums used for the normal sign.
   // ---------------------------------------------------------------
   logic                hit_ff, hit_in;
   logic [N-1:0]        sep;
   apcm_pkg::coord_type hi_ff [N], hi_in [N];
   apcm_pkg::coord_type lo_ff [N], lo_in [N];
   apcm_pkg::span_type  ov_ff [N], ov_in [N];
   apcm_pkg::span_type  ssum_ff [N], ssum_in [N];
   apcm_pkg::span_type  tsum_ff [N], tsum_in [N];
   apcm_pkg::coord_type bsmin_ff [N], bsmax_ff [N];

   always_comb begin
      for (int a = 0; a < N; a++) begin
         sep[a]     = (smin_ff[a] > tmax_ff[a]) || (tmin_ff[a] > smax_ff[a]);
         hi_in[a]   = (smax_ff[a] < tmax_ff[a]) ? smax_ff[a] : tmax_ff[a];
         lo_in[a]   = (smin_ff[a] > tmin_ff[a]) ? smin_ff[a] : tmin_ff[a];
         ov_in[a]   = apcm_pkg::widen_span(hi_in[a]) - apcm_pkg::widen_span(lo_in[a]);
         ssum_in[a] = apcm_pkg::widen_span(smax_ff[a]) + apcm_pkg::widen_span(smin_ff[a]);
         tsum_in[a] = apcm_pkg::widen_span(tmax_ff[a]) + apcm_pkg::widen_span(tmin_ff[a]);
      end
      hit_in = !(|sep);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         hit_ff   <= hit_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         ov_ff    <= ov_in;
         ssum_ff  <= ssum_in;
         tsum_ff  <= tsum_in;
         bsmin_ff <= smin_ff;
         bsmax_ff <= smax_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage C: least overlap (ties to the later axis), clamp, normal sign
   // from twice the centre difference, face plane; feeds the result stage.
   // ---------------------------------------------------------------
   apcm_pkg::span_type     pen_w;
   apcm_pkg::axis_type     axis;
   logic [N-1:0]           dneg;
   apcm_pkg::diff_type     dif [N];
   logic                   neg;
   apcm_pkg::coord_type    plane;
   apcm_pkg::manifold_type mf;

   always_comb begin
      for (int a = 0; a < N; a++) begin
         dif[a]  = apcm_pkg::widen_diff(tsum_ff[a]) - apcm_pkg::widen_diff(ssum_ff[a]);
         dneg[a] = dif[a][apcm_pkg::CoordWidth+1];
      end

      pen_w = ov_ff[0];
      axis  = apcm_pkg::AxisX;
      if (ov_ff[1] <= pen_w) begin
         pen_w = ov_ff[1];
         axis  = apcm_pkg::AxisY;
      end
      if (ov_ff[2] <= pen_w) begin
         pen_w = ov_ff[2];
         axis  = apcm_pkg::AxisZ;
      end

      unique case (axis)
         apcm_pkg::AxisX: begin
            neg   = dneg[0];
            plane = dneg[0] ? bsmin_ff[0] : bsmax_ff[0];
         end
         apcm_pkg::AxisY: begin
            neg   = dneg[1];
            plane = dneg[1] ? bsmin_ff[1] : bsmax_ff[1];
         end
         apcm_pkg::AxisZ: begin
            neg   = dneg[2];
            plane = dneg[2] ? bsmin_ff[2] : bsmax_ff[2];
         end
         default: begin
            neg   = 1'b0;
            plane = '0;
         end
      endcase

      mf.hit = hit_ff;
      for (int a = 0; a < N; a++) begin
         mf.hi[a] = hi_ff[a];
         mf.lo[a] = lo_ff[a];
      end
      if (hit_ff) begin
         mf.penetration = apcm_pkg::saturate_pen(pen_w);
         mf.axis        = axis;
         mf.negative    = neg;
         mf.plane       = plane;
      end else begin
         // a miss reports zero depth along +x
         mf.penetration = '0;
         mf.axis        = apcm_pkg::AxisX;
         mf.negative    = 1'b0;
         mf.plane       = '0;
      end
   end

   // ---------------------------------------------------------------
   // Result stage: one miss item or four contact items per pair.
   // ---------------------------------------------------------------
   apcm_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (vb_ff),
      .load_data  (mf),
      .take       (take),
      .rsp        (rsp)
   );

`ifndef ASSERT_OFF
   a_stall_holds_b: assert property (@(posedge clock) disable iff (reset)
      vb_ff && !take |=> vb_ff && $stable(hit_ff))
      else $error("overlap stage lost a pair while stalled");
   a_ready_when_a_empty: assert property (@(posedge clock) disable iff (reset)
      !va_ff |-> req.ready)
      else $error("input refused with empty first stage");
   a_no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      va_ff && !en_b |=> va_ff)
      else $error("first stage dropped a pair");
`endif

endmodule
